// ----- rtl/core/ddsr_pkg.sv -----
// Shared types and constants for the speed and turn-radius command converter.
package ddsr_pkg;

	localparam int LIN_W        = 23;
	localparam int ANG_W        = 25;
	localparam int WB_W         = 10;
	localparam int SPEED_W      = 15;
	localparam int RADIUS_W     = 27;
	localparam int MODE_W       = 2;
	localparam int LIN1000_W    = 32;
	localparam int RMAG_W       = 26;
	localparam int TERM_W       = 27;
	localparam int NUM_W        = 36;
	localparam int DSR_W        = 25;
	localparam int REM_W        = 25;
	localparam int DIV_STEP_N   = 2;
	localparam int DIV_CYCLES   = NUM_W / DIV_STEP_N;
	localparam int CNT_W        = $clog2(DIV_CYCLES);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int SCALE_SH     = 7;
	localparam int SCALE_IN_W   = 28;
	localparam int RECIP_W      = 29;
	localparam int RECIP_SH     = 42;
	localparam int RECIP_PROD_W = SCALE_IN_W + RECIP_W;

	localparam logic [WB_W-1:0]      WB_RESET   = WB_W'(230);
	localparam int                   SMALL_RATE = 100;
	localparam logic [LIN1000_W-1:0] MM_PER_M   = LIN1000_W'(1000);
	localparam logic [NUM_W-1:0]     LIN_TO_2M  = NUM_W'(2000);
	localparam logic [NUM_W-1:0]     HALF_2M    = NUM_W'(1000000);
	localparam logic [RECIP_W-1:0]   RECIP_2M   = RECIP_W'(281474977);

	typedef enum logic [MODE_W-1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_ROTATE   = 2'd1,
		MODE_ARC      = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic                  lin_neg;
		logic                  ang_neg;
		logic [LIN_W-1:0]      lin_mag;
		logic [ANG_W-1:0]      ang_mag;
		logic [LIN1000_W-1:0]  lin1000_mag;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/core/ddsr_if.sv -----
// Request and result channel interfaces of the command converter.
interface ddsr_cmd_if;
	logic                             valid;
	logic                             ready;
	logic signed [ddsr_pkg::LIN_W-1:0] lin_velocity;
	logic signed [ddsr_pkg::ANG_W-1:0] ang_velocity;

	modport source (output valid, output lin_velocity, output ang_velocity, input ready);
	modport sink (input valid, input lin_velocity, input ang_velocity, output ready);
endinterface

interface ddsr_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [ddsr_pkg::SPEED_W-1:0]  drive_speed;
	logic signed [ddsr_pkg::RADIUS_W-1:0] turn_radius;
	logic [ddsr_pkg::MODE_W-1:0]          drive_mode;

	modport source (output valid, output drive_speed, output turn_radius, output drive_mode,
		input ready);
	modport sink (input valid, input drive_speed, input turn_radius, input drive_mode,
		output ready);
endinterface

// ----- rtl/core/ddsr_front.sv -----
// Front end: takes velocity requests, forms magnitudes and classifies the drive mode.
module ddsr_front (
	input  logic                clk,
	input  logic                arst_n,
	ddsr_cmd_if.sink            cmd,
	input  ddsr_pkg::q_stat_t   qstat,
	output logic                push,
	output ddsr_pkg::entry_t    push_entry
);

	logic                              valid_s1;
	logic                              lin_neg_s1;
	logic                              ang_neg_s1;
	logic [ddsr_pkg::LIN_W-1:0]        lin_mag_s1;
	logic [ddsr_pkg::ANG_W-1:0]        ang_mag_s1;
	logic                              lin_neg;
	logic                              ang_neg;
	logic [ddsr_pkg::LIN_W-1:0]        lin_mag;
	logic [ddsr_pkg::ANG_W-1:0]        ang_mag;
	logic [ddsr_pkg::LIN1000_W-1:0]    lin1000;
	logic                              accept;
	logic                              is_straight;
	logic                              is_rotate;

	assign lin_neg = cmd.lin_velocity[ddsr_pkg::LIN_W-1];
	assign ang_neg = cmd.ang_velocity[ddsr_pkg::ANG_W-1];
	assign lin_mag = lin_neg ? (~cmd.lin_velocity + ddsr_pkg::LIN_W'(1)) : cmd.lin_velocity;
	assign ang_mag = ang_neg ? (~cmd.ang_velocity + ddsr_pkg::ANG_W'(1)) : cmd.ang_velocity;

	assign push      = valid_s1 && !qstat.full;
	assign cmd.ready = !valid_s1 || !qstat.full;
	assign accept    = cmd.valid && cmd.ready;

	assign lin1000     = ddsr_pkg::LIN1000_W'(lin_mag_s1) * ddsr_pkg::MM_PER_M;
	assign is_straight = ang_mag_s1 < ddsr_pkg::ANG_W'(ddsr_pkg::SMALL_RATE);
	assign is_rotate   = (lin_mag_s1 < ddsr_pkg::LIN_W'(ddsr_pkg::SMALL_RATE)) ||
		(lin1000 <= ddsr_pkg::LIN1000_W'(ang_mag_s1));

	always_comb begin
		push_entry.lin_neg     = lin_neg_s1;
		push_entry.ang_neg     = ang_neg_s1;
		push_entry.lin_mag     = lin_mag_s1;
		push_entry.ang_mag     = ang_mag_s1;
		push_entry.lin1000_mag = lin1000;
		if (is_straight) begin
			push_entry.mode = ddsr_pkg::MODE_STRAIGHT;
		end else if (is_rotate) begin
			push_entry.mode = ddsr_pkg::MODE_ROTATE;
		end else begin
			push_entry.mode = ddsr_pkg::MODE_ARC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lin_neg_s1 <= lin_neg;
			ang_neg_s1 <= ang_neg;
			lin_mag_s1 <= lin_mag;
			ang_mag_s1 <= ang_mag;
		end
	end

endmodule

// ----- rtl/core/ddsr_fifo.sv -----
// Short queue of classified requests between the front and back ends.
module ddsr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ddsr_pkg::entry_t    push_entry,
	input  logic                pop,
	output ddsr_pkg::entry_t    head,
	output ddsr_pkg::q_stat_t   qstat
);

	ddsr_pkg::entry_t                 mem_q [ddsr_pkg::FIFO_DEPTH];
	logic [ddsr_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [ddsr_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [ddsr_pkg::FIFO_AW:0]       count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = count_q == (ddsr_pkg::FIFO_AW+1)'(ddsr_pkg::FIFO_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ddsr_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ddsr_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (ddsr_pkg::FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (ddsr_pkg::FIFO_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/core/ddsr_back.sv -----
// Back end: radius division, speed product, rounded scaling and result register.
module ddsr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ddsr_pkg::WB_W-1:0]     wheelbase,
	input  ddsr_pkg::entry_t              head,
	input  ddsr_pkg::q_stat_t             qstat,
	output logic                          pop,
	ddsr_res_if.source                    res
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIVR  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_RND   = 6'b001000,
		ST_RECIP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                                  state_q;
	logic [ddsr_pkg::CNT_W-1:0]              div_cnt_q;
	logic                                    out_valid_q;
	ddsr_pkg::entry_t                        ent_q;
	logic [ddsr_pkg::REM_W-1:0]              div_rem_q;
	logic [ddsr_pkg::NUM_W-1:0]              div_quo_q;
	logic [ddsr_pkg::DSR_W-1:0]              div_dsr_q;
	logic [ddsr_pkg::TERM_W-1:0]             mul_a_q;
	logic [ddsr_pkg::NUM_W-1:0]              prod_q;
	logic [ddsr_pkg::RMAG_W-1:0]             rmag_q;
	logic [ddsr_pkg::SPEED_W-1:0]            spd_mag_q;
	logic signed [ddsr_pkg::SPEED_W-1:0]     out_speed_q;
	logic signed [ddsr_pkg::RADIUS_W-1:0]    out_radius_q;
	ddsr_pkg::mode_t                         out_mode_q;

	logic [ddsr_pkg::REM_W-1:0]              rem_nxt;
	logic [ddsr_pkg::NUM_W-1:0]              quo_nxt;
	logic [ddsr_pkg::TERM_W+ddsr_pkg::ANG_W-1:0] prod_full;
	logic [ddsr_pkg::RECIP_PROD_W-1:0]       recip_full;
	logic                                    div_last;
	logic                                    load_out;
	logic                                    speed_neg;
	logic                                    radius_neg;
	logic [ddsr_pkg::RADIUS_W-1:0]           radius_mag;
	logic signed [ddsr_pkg::SPEED_W-1:0]     speed_d;
	logic signed [ddsr_pkg::RADIUS_W-1:0]    radius_d;

	// Restoring divider, two quotient bits per cycle.
	always_comb begin
		logic [ddsr_pkg::REM_W:0] sh;
		rem_nxt = div_rem_q;
		quo_nxt = div_quo_q;
		for (int i = 0; i < ddsr_pkg::DIV_STEP_N; i++) begin
			sh      = {rem_nxt, quo_nxt[ddsr_pkg::NUM_W-1]};
			quo_nxt = {quo_nxt[ddsr_pkg::NUM_W-2:0], 1'b0};
			if (sh >= {1'b0, div_dsr_q}) begin
				sh         = sh - {1'b0, div_dsr_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = sh[ddsr_pkg::REM_W-1:0];
		end
	end

	// Division by 2000000 is a shift by seven and an exact reciprocal multiply for 15625.
	assign recip_full = ddsr_pkg::RECIP_PROD_W'(prod_q[ddsr_pkg::SCALE_SH +: ddsr_pkg::SCALE_IN_W]) *
		ddsr_pkg::RECIP_PROD_W'(ddsr_pkg::RECIP_2M);

	assign prod_full = mul_a_q * ent_q.ang_mag;
	assign div_last  = div_cnt_q == ddsr_pkg::CNT_W'(ddsr_pkg::DIV_CYCLES - 1);
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	assign speed_neg  = (ent_q.mode == ddsr_pkg::MODE_ROTATE) ? ent_q.ang_neg : ent_q.lin_neg;
	assign radius_neg = ent_q.lin_neg ^ ent_q.ang_neg;
	assign radius_mag = {1'b0, rmag_q};
	assign speed_d    = speed_neg ? (~spd_mag_q + ddsr_pkg::SPEED_W'(1)) : spd_mag_q;

	always_comb begin
		case (ent_q.mode)
			ddsr_pkg::MODE_STRAIGHT: radius_d = '0;
			ddsr_pkg::MODE_ROTATE:   radius_d = ddsr_pkg::RADIUS_W'(1);
			ddsr_pkg::MODE_ARC: begin
				radius_d = radius_neg ? (~radius_mag + ddsr_pkg::RADIUS_W'(1)) : radius_mag;
			end
			default: radius_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					if (pop) begin
						case (head.mode)
							ddsr_pkg::MODE_STRAIGHT: state_q <= ST_RND;
							ddsr_pkg::MODE_ROTATE:   state_q <= ST_MUL;
							ddsr_pkg::MODE_ARC:      state_q <= ST_DIVR;
							default:                 state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIVR: begin
					div_cnt_q <= div_cnt_q + ddsr_pkg::CNT_W'(1);
					if (div_last) begin
						div_cnt_q <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_RND;
				ST_RND:   state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					ent_q     <= head;
					div_rem_q <= '0;
					div_quo_q <= ddsr_pkg::NUM_W'(head.lin1000_mag);
					div_dsr_q <= head.ang_mag;
					mul_a_q   <= ddsr_pkg::TERM_W'(wheelbase);
					prod_q    <= ddsr_pkg::NUM_W'(head.lin_mag) * ddsr_pkg::LIN_TO_2M;
				end
			end
			ST_DIVR: begin
				div_rem_q <= rem_nxt;
				div_quo_q <= quo_nxt;
				if (div_last) begin
					rmag_q  <= quo_nxt[ddsr_pkg::RMAG_W-1:0];
					mul_a_q <= {quo_nxt[ddsr_pkg::RMAG_W-1:0], 1'b0} +
						ddsr_pkg::TERM_W'(wheelbase);
				end
			end
			ST_MUL:   prod_q <= prod_full[ddsr_pkg::NUM_W-1:0];
			ST_RND:   prod_q <= prod_q + ddsr_pkg::HALF_2M;
			ST_RECIP: spd_mag_q <= recip_full[ddsr_pkg::RECIP_SH +: ddsr_pkg::SPEED_W];
			ST_DONE: begin
				if (load_out) begin
					out_speed_q  <= speed_d;
					out_radius_q <= radius_d;
					out_mode_q   <= ent_q.mode;
				end
			end
			default: ;
		endcase
	end

	assign res.valid       = out_valid_q;
	assign res.drive_speed = out_speed_q;
	assign res.turn_radius = out_radius_q;
	assign res.drive_mode  = out_mode_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVR) |->
			(div_cnt_q < ddsr_pkg::CNT_W'(ddsr_pkg::DIV_CYCLES)))
		else $error("Divider count ran past its last step.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("Queue popped while empty.");

	a_rnd_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |=> (state_q == ST_RECIP && !prod_q[ddsr_pkg::NUM_W-1]))
		else $error("Speed scaling did not follow rounding with an in-range value.");

	a_straight_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && ent_q.mode == ddsr_pkg::MODE_STRAIGHT) |=>
			(out_valid_q && out_radius_q == '0))
		else $error("Straight-run result carries a non-zero radius.");

endmodule

// ----- rtl/core/diff_drive_speed_radius_command_top.sv -----
// Top level of the speed and turn-radius command converter.
// An accepted request passes the front register and the queue; the back end then steps through
// the radius division (general arc only), the speed multiply (rotation and arc), rounding,
// reciprocal scaling and the result register. The back end takes one request at a time, a
// general arc runs a two-bit-per-cycle radius division, and the speed uses a reciprocal multiply.
// Reset clears all handshake and sequencing state and sets the wheelbase to 230 mm.
module diff_drive_speed_radius_command_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ddsr_pkg::WB_W-1:0]     cfg_wr_data,
	ddsr_cmd_if.sink                      cmd,
	ddsr_res_if.source                    res
);

	logic [ddsr_pkg::WB_W-1:0]  wheelbase_q;
	logic                       push;
	logic                       pop;
	ddsr_pkg::entry_t           push_entry;
	ddsr_pkg::entry_t           head;
	ddsr_pkg::q_stat_t          qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= ddsr_pkg::WB_RESET;
		end else if (cfg_wr_en) begin
			wheelbase_q <= cfg_wr_data;
		end
	end

	ddsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	ddsr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	ddsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wheelbase (wheelbase_q),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res       (res)
	);

endmodule
